[rtl/bpsp_pkg.sv]
// Package for the base+size range text parser.
// Holds character codes, the parser phase enum, shared structs and the digit decoder.
// No dependencies.
package bpsp_pkg;

	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = CHAR_ZERO + 8'd9;
	localparam logic [7:0] CHAR_LOWER_X = 8'h78;
	localparam logic [7:0] CHAR_UPPER_X = 8'h58;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = CHAR_UPPER_A + 8'd5;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = CHAR_LOWER_A + 8'd5;
	localparam logic [7:0] HEX_LETTER_BASE = 8'd10;
	localparam logic [31:0] DEC_RADIX = 32'd10;

	typedef enum logic [2:0] {
		PH_START      = 3'd0,
		PH_BASE_FIRST = 3'd1,
		PH_BASE_ZERO  = 3'd2,
		PH_BASE_DIGIT = 3'd3,
		PH_SIZE_FIRST = 3'd4,
		PH_SIZE_ZERO  = 3'd5,
		PH_SIZE_DIGIT = 3'd6,
		PH_DONE       = 3'd7
	} bpsp_phase_t;

	typedef struct packed {
		bpsp_phase_t  phase;
		logic         hex_mode;
		logic         failed;
		logic [31:0]  base_accum;
		logic [31:0]  size_accum;
	} bpsp_state_t;

	typedef struct packed {
		logic         ok;
		logic [31:0]  base_value;
		logic [31:0]  size_value;
	} bpsp_result_t;

	typedef struct packed {
		logic        valid;
		logic [3:0]  value;
	} bpsp_digit_t;

	localparam bpsp_state_t BPSP_STATE_RESET = '{
		phase:      PH_START,
		hex_mode:   1'b0,
		failed:     1'b0,
		base_accum: 32'd0,
		size_accum: 32'd0
	};

	// Value of a character as a digit of the current radix.
	function automatic bpsp_digit_t digit_decode(input logic [7:0] c, input logic hex);
		bpsp_digit_t d;
		d.valid = 1'b0;
		d.value = 4'd0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d.valid = 1'b1;
			d.value = 4'(c - CHAR_ZERO);
		end else if (hex && c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
			d.valid = 1'b1;
			d.value = 4'(c - CHAR_UPPER_A + HEX_LETTER_BASE);
		end else if (hex && c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
			d.valid = 1'b1;
			d.value = 4'(c - CHAR_LOWER_A + HEX_LETTER_BASE);
		end
		return d;
	endfunction

endpackage

[rtl/bpsp_step.sv]
// Single-character update of the range text parser state, purely combinational.
// Depends on bpsp_pkg.
module bpsp_step import bpsp_pkg::*; (
	input  logic [7:0]    char_c,
	input  bpsp_state_t   cur,
	output bpsp_state_t   nxt,
	output bpsp_result_t  result
);

	bpsp_phase_t  ph;
	logic         in_base;
	logic         is_x;
	logic         skip;
	bpsp_digit_t  dig;
	logic [31:0]  acc_sel;
	logic [31:0]  acc_scaled;
	logic [31:0]  acc_new;
	bpsp_phase_t  ph_first;
	bpsp_phase_t  ph_zero;
	bpsp_phase_t  ph_digit;

	always_comb begin
		// The leading slash is consumed only in the start phase.
		ph   = (cur.phase == PH_START) ? PH_BASE_FIRST : cur.phase;
		skip = (cur.phase == PH_START) && (char_c == CHAR_SLASH);
		in_base = (ph == PH_BASE_FIRST) || (ph == PH_BASE_ZERO) || (ph == PH_BASE_DIGIT);
		is_x = (char_c == CHAR_LOWER_X) || (char_c == CHAR_UPPER_X);
		ph_first = in_base ? PH_BASE_FIRST : PH_SIZE_FIRST;
		ph_zero  = in_base ? PH_BASE_ZERO  : PH_SIZE_ZERO;
		ph_digit = in_base ? PH_BASE_DIGIT : PH_SIZE_DIGIT;

		// One shared scale-and-add (shift for hex, times ten for decimal) serves whichever number is being read.
		dig        = digit_decode(char_c, cur.hex_mode);
		acc_sel    = in_base ? cur.base_accum : cur.size_accum;
		acc_scaled = cur.hex_mode ? {acc_sel[27:0], 4'd0} : acc_sel * DEC_RADIX;
		acc_new    = acc_scaled + {28'd0, dig.value};
	end

	always_comb begin
		nxt = cur;
		if (!cur.failed && cur.phase != PH_DONE) begin
			nxt.phase = ph;
			if (!skip) begin
				if (in_base && char_c == CHAR_NUL) begin
					nxt.failed = 1'b1;
				end else if (in_base && char_c == CHAR_PLUS) begin
					nxt.phase    = PH_SIZE_FIRST;
					nxt.hex_mode = 1'b0;
				end else if (!in_base && (char_c == CHAR_NUL || char_c == CHAR_SLASH)) begin
					nxt.phase = PH_DONE;
				end else if (ph == ph_zero && is_x) begin
					nxt.hex_mode = 1'b1;
					nxt.phase    = ph_digit;
				end else if (!dig.valid) begin
					nxt.failed = 1'b1;
				end else begin
					if (in_base) begin
						nxt.base_accum = acc_new;
					end else begin
						nxt.size_accum = acc_new;
					end
					nxt.phase = (ph == ph_first && char_c == CHAR_ZERO) ? ph_zero : ph_digit;
				end
			end
		end
	end

	always_comb begin
		result.ok = !nxt.failed && nxt.size_accum != 32'd0 &&
			(nxt.phase == PH_SIZE_FIRST || nxt.phase == PH_SIZE_ZERO ||
			 nxt.phase == PH_SIZE_DIGIT || nxt.phase == PH_DONE);
		result.base_value = result.ok ? nxt.base_accum : 32'd0;
		result.size_value = result.ok ? nxt.size_accum : 32'd0;
	end

endmodule

[rtl/base_plus_size_text_parser_top.sv]
// Top level of the base+size range text parser: input register, parser state and result register.
// Depends on bpsp_pkg and bpsp_step.
//
// This block reads a range text of the form base+size, one character per transfer on the input
// channel, and produces one result transfer for the character marked last_char. A single
// leading slash is skipped; each number is decimal, or hexadecimal when it starts with 0x or 0X;
// the base ends at a plus sign and the size ends at a slash or a zero byte, after which all
// characters are ignored. Both numbers wrap modulo 2^32. parse_ok is low for a bad digit, a
// missing plus or a zero size, and then base_value and size_value read as zero. The block takes
// one character per clock cycle unless the output side stalls: each character passes an input
// register, then one pass of the scale-and-add step logic updates the parser state, and the final
// character's result lands in the output register. The only stall comes from the output side: a
// last character waits in the input register while an earlier result is still untaken. After each
// result the parser returns to its reset state, so the next character starts a new text.
module base_plus_size_text_parser_top import bpsp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   char_in,
	input  logic         last_char,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         parse_ok,
	output logic [31:0]  base_value,
	output logic [31:0]  size_value
);

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          last_s1;
	logic          consume_s1;
	bpsp_state_t   state_q;
	bpsp_state_t   state_nxt;
	bpsp_result_t  step_result;
	logic          out_valid_q;
	bpsp_result_t  result_q;

	// The registered character leaves the input stage unless it is a last character whose
	// result has nowhere to go yet.
	assign consume_s1 = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || consume_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
			last_s1 <= last_char;
		end
	end

	bpsp_step u_step (
		.char_c (char_s1),
		.cur    (state_q),
		.nxt    (state_nxt),
		.result (step_result)
	);

	// Parser state advances once per consumed character and clears after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BPSP_STATE_RESET;
		end else if (consume_s1) begin
			state_q <= last_s1 ? BPSP_STATE_RESET : state_nxt;
		end
	end

	// A new result takes the output register even when the previous one leaves at this edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume_s1 && last_s1) begin
			result_q <= step_result;
		end
	end

	assign out_valid  = out_valid_q;
	assign parse_ok   = result_q.ok;
	assign base_value = result_q.base_value;
	assign size_value = result_q.size_value;

endmodule
